[rtl/core/assert_macros.svh]
// Assertion helpers for the queue core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define HPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a property holds at every clock edge, reset included.
`define HPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/hpq_pkg.sv]
package hpq_pkg;

  localparam logic [1:0] CMD_PUSH      = 2'd0;
  localparam logic [1:0] CMD_POP_LOW   = 2'd1;
  localparam logic [1:0] CMD_POP_LEVEL = 2'd2;
  localparam logic [1:0] CMD_FLUSH     = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] point;
    logic [7:0]  level;
  } hpq_in_t;

  typedef struct packed {
    logic [31:0] popped_point;
    logic [1:0]  status;
    logic        queue_empty;
    logic [8:0]  current_level;
    logic [12:0] occupancy;
  } hpq_out_t;

endpackage

[rtl/core/hpq_ram.sv]
module hpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

endmodule

[rtl/core/hierarchical_priority_queue.sv]
// Hierarchical priority queue: one FIFO of point indices per level, all
// levels sharing one pool of entries held on a free list.
// Input channel in_valid/in_ready/in_data carries a command (push, pop the
// lowest level, pop a named level, flush), a point and a level. Every input
// beat yields exactly one result beat on out_valid/out_ready/out_data with
// the popped point, a status code, the empty flag, the current level and the
// occupancy after the command.
// One command is worked at a time. Refused commands and flush go straight to
// the done state; a push passes PU_A, PU_B and, if its level holds points,
// PU_C; a pop passes PO_A, PO_B and PO_C, as the link memory accesses need.
// A pop that empties the current level then scans the nonempty bitmap one
// level per cycle until a nonempty level or the last level is passed.
// The result sits in an output register; the next command is accepted and
// worked while it waits, and only its own result waits for the register.
// Reset (synchronous, active low) empties the queue at once; no memory
// sweep is needed, since the free head, fresh mark and bitmap are flops.
module hierarchical_priority_queue #(
  parameter int CAPACITY = 4096,
  parameter int LEVELS   = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  hpq_pkg::hpq_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output hpq_pkg::hpq_out_t out_data
);
  import hpq_pkg::*;

  localparam int EIW = $clog2(CAPACITY);
  localparam int LW  = $clog2(CAPACITY + 1);
  localparam int LIW = $clog2(LEVELS);
  localparam int LLW = $clog2(LEVELS + 1);
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_PU_A = 9'b000000010,
    S_PU_B = 9'b000000100,
    S_PU_C = 9'b000001000,
    S_PO_A = 9'b000010000,
    S_PO_B = 9'b000100000,
    S_PO_C = 9'b001000000,
    S_SCAN = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t            state_r;
  logic [31:0]       pt_r;
  logic [LIW-1:0]    lv_r;
  logic [EIW-1:0]    e_r;
  logic [EIW-1:0]    old_r;
  logic [31:0]       popped_r;
  logic [1:0]        status_r;
  logic [LW-1:0]     free_head_r;
  logic [LW-1:0]     fresh_r;
  logic [LW-1:0]     held_r;
  logic [LLW-1:0]    lowest_r;
  logic [LEVELS-1:0] ne_r;
  hpq_out_t          out_r;
  logic              out_valid_r;

  logic              pt_we;
  logic [EIW-1:0]    pt_waddr;
  logic [EIW-1:0]    ent_raddr;
  logic [31:0]       pt_rdata;
  logic              nx_we;
  logic [EIW-1:0]    nx_waddr;
  logic [LW-1:0]     nx_wdata;
  logic [LW-1:0]     nx_rdata;
  logic              ln_we;
  logic [EIW-1:0]    ln_rdata;
  logic              lo_we;
  logic [EIW-1:0]    lo_wdata;
  logic [EIW-1:0]    lo_rdata;
  logic              bad_level;
  logic [LIW-1:0]    in_lv;
  logic [LLW-1:0]    cand;

  assign bad_level = 32'(in_data.level) >= 32'(LEVELS);
  assign in_lv     = LIW'(in_data.level);
  assign cand      = lowest_r + 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Memory port control, one access of each kind per state.
  always_comb begin
    pt_we     = (state_r == S_PU_B);
    pt_waddr  = free_head_r[EIW-1:0];
    ent_raddr = (state_r == S_PO_B) ? lo_rdata : free_head_r[EIW-1:0];
    nx_we     = 1'b0;
    nx_waddr  = free_head_r[EIW-1:0];
    nx_wdata  = NIL;
    ln_we     = (state_r == S_PU_B);
    lo_we     = 1'b0;
    lo_wdata  = free_head_r[EIW-1:0];
    case (state_r)
      S_PU_B: begin
        nx_we = 1'b1;
        lo_we = !ne_r[lv_r];
      end
      S_PU_C: begin
        nx_we    = 1'b1;
        nx_waddr = old_r;
        nx_wdata = LW'(e_r);
      end
      S_PO_C: begin
        nx_we    = 1'b1;
        nx_waddr = e_r;
        nx_wdata = free_head_r;
        lo_we    = (nx_rdata != NIL);
        lo_wdata = nx_rdata[EIW-1:0];
      end
      default: begin
      end
    endcase
  end

  hpq_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ent_pt (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_r),
    .raddr(ent_raddr), .rd_data_r(pt_rdata)
  );

  hpq_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_ent_nx (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(ent_raddr), .rd_data_r(nx_rdata)
  );

  hpq_ram #(.WIDTH(EIW), .DEPTH(LEVELS)) u_lvl_new (
    .clk(clk), .we(ln_we), .waddr(lv_r), .wdata(free_head_r[EIW-1:0]),
    .raddr(lv_r), .rd_data_r(ln_rdata)
  );

  hpq_ram #(.WIDTH(EIW), .DEPTH(LEVELS)) u_lvl_old (
    .clk(clk), .we(lo_we), .waddr(lv_r), .wdata(lo_wdata),
    .raddr(lv_r), .rd_data_r(lo_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_head_r <= '0;
      fresh_r     <= '0;
      held_r      <= '0;
      lowest_r    <= '0;
      ne_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // The done state reloads the output register itself.
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            pt_r     <= in_data.point;
            popped_r <= '0;
            case (in_data.command)
              CMD_PUSH: begin
                lv_r <= in_lv;
                if (bad_level || free_head_r == NIL) begin
                  status_r <= ST_FULL;
                  state_r  <= S_DONE;
                end else begin
                  status_r <= ST_OK;
                  state_r  <= S_PU_A;
                end
              end
              CMD_POP_LOW: begin
                lv_r <= lowest_r[LIW-1:0];
                if (held_r == '0) begin
                  status_r <= ST_EMPTY;
                  state_r  <= S_DONE;
                end else begin
                  status_r <= ST_OK;
                  state_r  <= S_PO_A;
                end
              end
              CMD_POP_LEVEL: begin
                lv_r <= in_lv;
                if (bad_level || !ne_r[in_lv]) begin
                  status_r <= ST_EMPTY;
                  state_r  <= S_DONE;
                end else begin
                  status_r <= ST_OK;
                  state_r  <= S_PO_A;
                end
              end
              default: begin
                lv_r        <= in_lv;
                status_r    <= ST_OK;
                state_r     <= S_DONE;
                free_head_r <= '0;
                fresh_r     <= '0;
                held_r      <= '0;
                lowest_r    <= '0;
                ne_r        <= '0;
              end
            endcase
          end
        end
        S_PU_A: begin
          state_r <= S_PU_B;
        end
        S_PU_B: begin
          // Entries at or past the fresh mark were never allocated and
          // still chain in index order, so their links need no memory.
          if (free_head_r == fresh_r) begin
            fresh_r     <= fresh_r + 1'b1;
            free_head_r <= fresh_r + 1'b1;
          end else begin
            free_head_r <= nx_rdata;
          end
          if (held_r == '0 || LLW'(lv_r) < lowest_r) begin
            lowest_r <= LLW'(lv_r);
          end
          held_r   <= held_r + 1'b1;
          e_r      <= free_head_r[EIW-1:0];
          old_r    <= ln_rdata;
          ne_r[lv_r] <= 1'b1;
          state_r  <= ne_r[lv_r] ? S_PU_C : S_DONE;
        end
        S_PU_C: begin
          state_r <= S_DONE;
        end
        S_PO_A: begin
          state_r <= S_PO_B;
        end
        S_PO_B: begin
          e_r     <= lo_rdata;
          state_r <= S_PO_C;
        end
        S_PO_C: begin
          popped_r    <= pt_rdata;
          free_head_r <= LW'(e_r);
          held_r      <= held_r - 1'b1;
          if (nx_rdata == NIL) begin
            ne_r[lv_r] <= 1'b0;
          end
          state_r <= (nx_rdata == NIL && LLW'(lv_r) == lowest_r) ? S_SCAN : S_DONE;
        end
        S_SCAN: begin
          lowest_r <= cand;
          if (cand == LLW'(LEVELS) || ne_r[cand[LIW-1:0]]) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_r.popped_point  <= popped_r;
            out_r.status        <= status_r;
            out_r.queue_empty   <= (held_r == '0);
            out_r.current_level <= (held_r == '0) ? 9'(LEVELS) : 9'(lowest_r);
            out_r.occupancy     <= 13'(held_r);
            out_valid_r         <= 1'b1;
            state_r             <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`include "assert_macros.svh"

  `HPQ_ASSERT(a_held_range, held_r <= LW'(CAPACITY), "held count above capacity")
  `HPQ_ASSERT(a_fresh_cover, held_r <= fresh_r, "more points held than entries used")
  `HPQ_ASSERT(a_lowest_valid, (state_r == S_IDLE && held_r != '0) |-> (lowest_r < LLW'(LEVELS) && ne_r[lowest_r[LIW-1:0]]), "current level not a nonempty level")
  `HPQ_ASSERT(a_one_at_a_time, (in_valid && in_ready) |=> !in_ready, "second command taken while busy")
  `HPQ_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE && !out_valid_r), "reset left work pending")

endmodule
